/* hw/rtl/uartrb_pkg.sv */
package uartrb_pkg;

  // operation codes (s_tuser)
  localparam logic [2:0] OP_LINE_BYTE = 3'd0;
  localparam logic [2:0] OP_RX_ERROR  = 3'd1;
  localparam logic [2:0] OP_SW_READ   = 3'd2;
  localparam logic [2:0] OP_SW_WRITE  = 3'd3;
  localparam logic [2:0] OP_TX_READY  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_RX_SIZE   = 2'd0;
  localparam logic [1:0] CFG_TX_SIZE   = 2'd1;
  localparam logic [1:0] CFG_WAKE_TASK = 2'd2;

  localparam logic [8:0] SIZE_RESET = 9'd256;

  typedef struct packed {
    logic [8:0]  rx_size;
    logic [8:0]  tx_size;
    logic [15:0] wake_task;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data_out;
    logic        data_valid;
    logic        last;
    logic [7:0]  rx_available;
    logic [15:0] overflow_count;
    logic [15:0] error_count;
    logic        notify;
    logic [15:0] notify_task;
  } result_t;

  // advance a ring index, wrapping at the ring size
  function automatic logic [8:0] ring_next(logic [8:0] idx, logic [8:0] size);
    logic [8:0] n;
    n = idx + 9'd1;
    return (n >= size) ? 9'd0 : n;
  endfunction

  // bytes held between read and write index, modulo 256
  function automatic logic [7:0] ring_fill(logic [8:0] wr, logic [8:0] rd,
                                           logic [8:0] size);
    logic [9:0] d;
    if (size == 9'd0) begin
      d = 10'd0;
    end else if (wr >= rd) begin
      d = {1'b0, wr} - {1'b0, rd};
    end else begin
      d = {1'b0, size} + {1'b0, wr} - {1'b0, rd};
    end
    return d[7:0];
  endfunction

endpackage

/* hw/rtl/uartrb_ram.sv */
module uartrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/uartrb_core.sv */
module uartrb_core
  import uartrb_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int MAX_READ   = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [7:0] in_data,
  input  logic [6:0] in_count,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  // sizes are 9 bits, so no index ever exceeds 510
  localparam int EFF_MAX = (RING_DEPTH > 511) ? 511 : RING_DEPTH;
  localparam int AW      = $clog2(EFF_MAX);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_WALK    = 3'd2;
  localparam logic [2:0] S_RD_EMIT = 3'd3;
  localparam logic [2:0] S_RD_WAIT = 3'd4;

  logic [2:0]    state, state_next;
  logic [2:0]    op;
  logic [7:0]    din;
  logic [6:0]    cnt;
  logic [AW-1:0] rx_wr, rx_wr_next, rx_rd, rx_rd_next;
  logic [AW-1:0] tx_wr, tx_wr_next, tx_rd, tx_rd_next;
  logic [AW-1:0] walk_idx, walk_idx_next;
  logic [6:0]    walk_n, walk_n_next;
  logic [6:0]    remain, remain_next;
  logic [7:0]    avail, avail_next;
  logic [15:0]   dropped, dropped_next;
  logic [15:0]   errs, errs_next;

  logic          emit;
  result_t       res;
  logic          rx_we, tx_we;
  logic [7:0]    rx_rdata, tx_rdata;

  logic [8:0]    rx_eff, tx_eff;
  logic [8:0]    rx_wr9, rx_rd9, tx_wr9, tx_rd9, walk9;
  logic [8:0]    rx_wr_adv, rx_rd_adv, tx_wr_adv, tx_rd_adv, walk_adv;
  logic          out_free;
  logic [6:0]    cnt_cap;

  assign rx_eff = (cfg.rx_size > 9'(EFF_MAX)) ? 9'(EFF_MAX) : cfg.rx_size;
  assign tx_eff = (cfg.tx_size > 9'(EFF_MAX)) ? 9'(EFF_MAX) : cfg.tx_size;

  assign rx_wr9 = 9'(rx_wr);
  assign rx_rd9 = 9'(rx_rd);
  assign tx_wr9 = 9'(tx_wr);
  assign tx_rd9 = 9'(tx_rd);
  assign walk9  = 9'(walk_idx);

  assign rx_wr_adv = ring_next(rx_wr9, rx_eff);
  assign rx_rd_adv = ring_next(rx_rd9, rx_eff);
  assign tx_wr_adv = ring_next(tx_wr9, tx_eff);
  assign tx_rd_adv = ring_next(tx_rd9, tx_eff);
  assign walk_adv  = ring_next(walk9, rx_eff);

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign cnt_cap  = (in_count > 7'(MAX_READ)) ? 7'(MAX_READ) : in_count;

  uartrb_ram #(.WIDTH(8), .DEPTH(EFF_MAX)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr),
    .wdata (din),
    .raddr (rx_rd),
    .rdata (rx_rdata)
  );

  uartrb_ram #(.WIDTH(8), .DEPTH(EFF_MAX)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr),
    .wdata (din),
    .raddr (tx_rd),
    .rdata (tx_rdata)
  );

  always_comb begin
    state_next    = state;
    rx_wr_next    = rx_wr;
    rx_rd_next    = rx_rd;
    tx_wr_next    = tx_wr;
    tx_rd_next    = tx_rd;
    walk_idx_next = walk_idx;
    walk_n_next   = walk_n;
    remain_next   = remain;
    avail_next    = avail;
    dropped_next  = dropped;
    errs_next     = errs;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    emit          = 1'b0;

    res                = '0;
    res.status         = ST_DONE;
    res.last           = 1'b1;
    res.rx_available   = ring_fill(rx_wr9, rx_rd9, rx_eff);
    res.overflow_count = dropped;
    res.error_count    = errs;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          walk_idx_next = rx_rd;
          walk_n_next   = 7'd0;
          state_next    = (in_op == OP_SW_READ) ? S_WALK : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          case (op)
            OP_LINE_BYTE: begin
              if (rx_wr_adv != rx_rd9) begin
                rx_we            = 1'b1;
                rx_wr_next       = AW'(rx_wr_adv);
                res.rx_available = ring_fill(rx_wr_adv, rx_rd9, rx_eff);
                res.notify       = (cfg.wake_task != 16'd0);
                res.notify_task  = cfg.wake_task;
              end else begin
                dropped_next       = dropped + 16'd1;
                res.status         = ST_FULL;
                res.overflow_count = dropped_next;
              end
            end
            OP_RX_ERROR: begin
              errs_next       = errs + 16'd1;
              res.error_count = errs_next;
            end
            OP_SW_READ: begin
              // only reached when the walk found nothing to read
              res.status = (cnt == 7'd0) ? ST_DONE : ST_EMPTY;
            end
            OP_SW_WRITE: begin
              if (tx_wr_adv != tx_rd9) begin
                tx_we      = 1'b1;
                tx_wr_next = AW'(tx_wr_adv);
              end else begin
                res.status = ST_FULL;
              end
            end
            OP_TX_READY: begin
              if (tx_wr != tx_rd) begin
                res.data_out   = tx_rdata;
                res.data_valid = 1'b1;
                tx_rd_next     = AW'(tx_rd_adv);
              end else begin
                res.status = ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // step a scratch index to find the burst length and the final fill
      S_WALK: begin
        if (walk_n == cnt || walk_idx == rx_wr) begin
          avail_next  = ring_fill(rx_wr9, walk9, rx_eff);
          remain_next = walk_n;
          state_next  = (walk_n == 7'd0) ? S_EXEC : S_RD_EMIT;
        end else begin
          walk_idx_next = AW'(walk_adv);
          walk_n_next   = walk_n + 7'd1;
        end
      end

      S_RD_EMIT: begin
        res.data_out     = rx_rdata;
        res.data_valid   = 1'b1;
        res.last         = (remain == 7'd1);
        res.rx_available = avail;
        if (out_free) begin
          emit        = 1'b1;
          rx_rd_next  = AW'(rx_rd_adv);
          remain_next = remain - 7'd1;
          state_next  = (remain == 7'd1) ? S_IDLE : S_RD_WAIT;
        end
      end

      // new read address goes out; data lands next cycle
      S_RD_WAIT: begin
        state_next = S_RD_EMIT;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rx_wr     <= '0;
      rx_rd     <= '0;
      tx_wr     <= '0;
      tx_rd     <= '0;
      dropped   <= '0;
      errs      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rx_wr     <= rx_wr_next;
      rx_rd     <= rx_rd_next;
      tx_wr     <= tx_wr_next;
      tx_rd     <= tx_rd_next;
      dropped   <= dropped_next;
      errs      <= errs_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op  <= in_op;
      din <= in_data;
      cnt <= cnt_cap;
    end
    walk_idx <= walk_idx_next;
    walk_n   <= walk_n_next;
    remain   <= remain_next;
    avail    <= avail_next;
    if (emit) begin
      out_res <= res;
    end
  end

endmodule

/* hw/rtl/uart_rx_tx_ring_buffers_top.sv */
// A single-result beat moves to the execute state on acceptance and executes once the
//   result register is free; its result is presented the cycle after it executes.
// A read holds the input through acceptance and a walk that counts the bytes to read,
//   then an emit per byte with a wait between, paced by the RAM's one read port.
// Reset (rst, sync, active high): indices and counters clear, sizes go to 256,
//   wake task to 0; RAM contents are not cleared.
module uart_rx_tx_ring_buffers_top
  import uartrb_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int MAX_READ   = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_in, [14:8] count, [15] zero
  input  logic [2:0]  s_tuser,   // [2:0] operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [1:0] status, [9:2] data_out, [17:10] rx_available,
                                 // [33:18] overflow_count, [49:34] error_count,
                                 // [50] notify, [66:51] notify_task, [71:67] zero
  output logic        m_tuser,   // [0] data_valid
  output logic        m_tlast,   // last result beat of an input beat
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  result_t res;

  // config registers; index 3 is not decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_size   <= SIZE_RESET;
      cfg.tx_size   <= SIZE_RESET;
      cfg.wake_task <= 16'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RX_SIZE:   cfg.rx_size   <= cfg_data[8:0];
        CFG_TX_SIZE:   cfg.tx_size   <= cfg_data[8:0];
        CFG_WAKE_TASK: cfg.wake_task <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer with both ring RAMs and the result register
  uartrb_core #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_data   (s_tdata[7:0]),
    .in_count  (s_tdata[14:8]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {5'd0, res.notify_task, res.notify, res.error_count,
                    res.overflow_count, res.rx_available, res.data_out, res.status};
  assign m_tuser = res.data_valid;
  assign m_tlast = res.last;

endmodule

/* verif/uart_rings_checker.sv */
`timescale 1ns / 1ps
module uart_rings_checker
  import uartrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_in, [14:8] count, [15] zero
  input  logic [2:0]  s_tuser,   // [2:0] operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // [1:0] status, [9:2] data_out, [17:10] rx_available,
                                 // [33:18] overflow_count, [49:34] error_count,
                                 // [50] notify, [66:51] notify_task, [71:67] zero
  input  logic        m_tuser,   // [0] data_valid
  input  logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          owed,
  output int          beats_checked,
  output logic        rx_busy,
  output logic        tx_busy
);

  localparam int READ_CAP = 64;
  localparam logic [8:0] SLOT_CAP = 9'd256;

  logic [7:0]  rx_mem [256];
  logic [7:0]  tx_mem [256];
  logic [8:0]  rx_wr, rx_rd, tx_wr, tx_rd;
  logic [15:0] dropped, line_errs;
  logic [8:0]  rx_slots, tx_slots;
  logic [15:0] task_id;
  result_t     owed_results[$];

  assign rx_busy = (rx_wr != rx_rd);
  assign tx_busy = (tx_wr != tx_rd);

  function automatic logic [8:0] usable(input logic [8:0] slots);
    return (slots > SLOT_CAP) ? SLOT_CAP : slots;
  endfunction

  // wrap to slot 0 once the step reaches the ring size
  function automatic logic [8:0] bump(input logic [8:0] idx, input logic [8:0] slots);
    logic [9:0] n;
    n = {1'b0, idx} + 10'd1;
    if (n >= {1'b0, slots}) return 9'd0;
    return n[8:0];
  endfunction

  // receive occupancy, mod 256 (indices may sit past a shrunk size)
  function automatic logic [7:0] rx_fill();
    int d;
    if (usable(rx_slots) == 9'd0) return 8'd0;
    d = int'(rx_wr) - int'(rx_rd);
    if (d < 0) d += int'(usable(rx_slots));
    return d[7:0];
  endfunction

  function automatic void owe(input logic [1:0] st, input logic [7:0] b, input logic v,
                              input logic l, input logic ntf);
    result_t r;
    r.status         = st;
    r.data_out       = b;
    r.data_valid     = v;
    r.last           = l;
    r.rx_available   = rx_fill();
    r.overflow_count = dropped;
    r.error_count    = line_errs;
    r.notify         = ntf;
    r.notify_task    = ntf ? task_id : 16'd0;
    owed_results.push_back(r);
  endfunction

  task automatic advance_rings(input logic [2:0] op, input logic [7:0] b,
                               input logic [6:0] cnt);
    logic [8:0] nxt;
    logic [7:0] taken[$];
    int lim;
    case (op)
      OP_LINE_BYTE: begin
        nxt = bump(rx_wr, usable(rx_slots));
        if (nxt != rx_rd) begin
          rx_mem[rx_wr[7:0]] = b;
          rx_wr = nxt;
          owe(ST_DONE, 8'd0, 1'b0, 1'b1, task_id != 16'd0);
        end else begin
          dropped = dropped + 16'd1;
          owe(ST_FULL, 8'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      OP_RX_ERROR: begin
        line_errs = line_errs + 16'd1;
        owe(ST_DONE, 8'd0, 1'b0, 1'b1, 1'b0);
      end
      OP_SW_READ: begin
        lim = (int'(cnt) > READ_CAP) ? READ_CAP : int'(cnt);
        while (taken.size() < lim && rx_wr != rx_rd) begin
          taken.push_back(rx_mem[rx_rd[7:0]]);
          rx_rd = bump(rx_rd, usable(rx_slots));
        end
        if (taken.size() == 0) begin
          owe((cnt == 7'd0) ? ST_DONE : ST_EMPTY, 8'd0, 1'b0, 1'b1, 1'b0);
        end else begin
          foreach (taken[i]) owe(ST_DONE, taken[i], 1'b1, i == taken.size() - 1, 1'b0);
        end
      end
      OP_SW_WRITE: begin
        nxt = bump(tx_wr, usable(tx_slots));
        if (nxt != tx_rd) begin
          tx_mem[tx_wr[7:0]] = b;
          tx_wr = nxt;
          owe(ST_DONE, 8'd0, 1'b0, 1'b1, 1'b0);
        end else begin
          owe(ST_FULL, 8'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      OP_TX_READY: begin
        if (tx_wr != tx_rd) begin
          owe(ST_DONE, tx_mem[tx_rd[7:0]], 1'b1, 1'b1, 1'b0);
          tx_rd = bump(tx_rd, usable(tx_slots));
        end else begin
          owe(ST_EMPTY, 8'd0, 1'b0, 1'b1, 1'b0);
        end
      end
      default: owe(ST_DONE, 8'd0, 1'b0, 1'b1, 1'b0);
    endcase
  endtask

  task automatic miss(input string field, input logic [15:0] want_v,
                      input logic [15:0] got_v);
    $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
    fail_count++;
  endtask

  task automatic check_beat();
    result_t want;
    if (owed_results.size() == 0) begin
      $error("result beat with nothing outstanding: tdata 0x%0h", m_tdata);
      fail_count++;
      return;
    end
    want = owed_results.pop_front();
    beats_checked++;
    if (m_tdata[1:0] !== want.status)          miss("status", 16'(want.status),
                                                    16'(m_tdata[1:0]));
    if (m_tdata[9:2] !== want.data_out)        miss("data_out", 16'(want.data_out),
                                                    16'(m_tdata[9:2]));
    if (m_tuser !== want.data_valid)           miss("data_valid", 16'(want.data_valid),
                                                    16'(m_tuser));
    if (m_tlast !== want.last)                 miss("last", 16'(want.last), 16'(m_tlast));
    if (m_tdata[17:10] !== want.rx_available)  miss("rx_available", 16'(want.rx_available),
                                                    16'(m_tdata[17:10]));
    if (m_tdata[33:18] !== want.overflow_count) miss("overflow_count", want.overflow_count,
                                                     m_tdata[33:18]);
    if (m_tdata[49:34] !== want.error_count)   miss("error_count", want.error_count,
                                                    m_tdata[49:34]);
    if (m_tdata[50] !== want.notify)           miss("notify", 16'(want.notify),
                                                    16'(m_tdata[50]));
    if (m_tdata[66:51] !== want.notify_task)   miss("notify_task", want.notify_task,
                                                    m_tdata[66:51]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_wr = '0;
      rx_rd = '0;
      tx_wr = '0;
      tx_rd = '0;
      dropped = '0;
      line_errs = '0;
      rx_slots = SIZE_RESET;
      tx_slots = SIZE_RESET;
      task_id = '0;
      owed_results.delete();
      fail_count = 0;
      beats_checked = 0;
    end else begin
      // result first: a beat accepted at this edge cannot answer itself
      if (m_tvalid && m_tready) check_beat();
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_RX_SIZE:   rx_slots = cfg_data[8:0];
          CFG_TX_SIZE:   tx_slots = cfg_data[8:0];
          CFG_WAKE_TASK: task_id = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) advance_rings(s_tuser, s_tdata[7:0], s_tdata[14:8]);
    end
    owed = owed_results.size();
  end

endmodule

/* verif/tb_uart_rx_tx_ring_buffers_top.sv */
`timescale 1ns / 1ps
module tb_uart_rx_tx_ring_buffers_top;
  import uartrb_pkg::*;

  localparam int PHASES      = 7;   // random phases, each with its own ring setup
  localparam int PHASE_ITEMS = 12;  // random beats per phase
  localparam int GAP_ODDS    = 4;   // 1 in N beats is preceded by a sender gap

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // [7:0] data_in, [14:8] count, [15] zero
  logic [2:0]  s_tuser   = '0;   // [2:0] operation
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;          // [1:0] status, [9:2] data_out, [17:10] rx_available,
                                 // [33:18] overflow_count, [49:34] error_count,
                                 // [50] notify, [66:51] notify_task, [71:67] zero
  logic        m_tuser;          // [0] data_valid
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_RX_SIZE;
  logic [15:0] cfg_data  = '0;

  int   fails, owed_count, checked;
  logic rx_busy, tx_busy;

  int sent       = 0;   // input beats accepted
  int setups     = 0;   // ring configurations programmed
  int stall_left = 0;
  bit calm       = 1'b0; // no idling on either side while set

  always #1 clk = ~clk;

  uart_rx_tx_ring_buffers_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  uart_rings_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .owed          (owed_count),
    .beats_checked (checked),
    .rx_busy       (rx_busy),
    .tx_busy       (tx_busy)
  );

  // Receiver back-pressure: random stall bursts, none started while calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One input beat; holds tvalid until accepted. Optional sender gap first.
  task automatic push_item(input logic [2:0] op, input logic [7:0] b, input logic [6:0] cnt);
    if (!calm && $urandom_range(0, GAP_ODDS - 1) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, cnt, b};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Stop sending, wait for every owed result, then a margin for the pipeline.
  // Checker outputs are sampled on the falling edge to stay clear of the update.
  task automatic settle(input int extra);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (owed_count != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Empty both rings so a size change never leaves stale slots to be read.
  task automatic drain_rings();
    settle(16);
    while (rx_busy || tx_busy) begin
      if (rx_busy) push_item(OP_SW_READ, 8'h00, 7'd64);
      if (tx_busy) push_item(OP_TX_READY, 8'h00, 7'd1);
      settle(16);
    end
  endtask

  // Writes all three registers on back-to-back edges while the block is idle.
  task automatic program_rings(input logic [8:0] rx, input logic [8:0] tx,
                               input logic [15:0] id);
    drain_rings();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_RX_SIZE;
    cfg_data  <= {7'd0, rx};
    @(posedge clk);
    cfg_index <= CFG_TX_SIZE;
    cfg_data  <= {7'd0, tx};
    @(posedge clk);
    cfg_index <= CFG_WAKE_TASK;
    cfg_data  <= id;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    setups++;
  endtask

  // Mostly small rings so full/overflow shows up; sizes past 256 saturate.
  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd511;
      3:       return SIZE_RESET;
      4:       return 9'($urandom_range(257, 510));
      default: return 9'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 2))
      0:       return 16'h0000;   // notification off
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int pick;
    logic [2:0] op;
    logic [6:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_LINE_BYTE;
    else if (pick < 60) op = OP_SW_WRITE;
    else if (pick < 75) op = OP_TX_READY;
    else if (pick < 90) op = OP_SW_READ;
    else if (pick < 95) op = OP_RX_ERROR;
    else                op = OP_TX_READY + 3'($urandom_range(1, 3));  // unused codes
    // read length: short bursts mostly, plus zero, the cap and above the cap
    pick = $urandom_range(0, 19);
    if (pick == 0)      cnt = 7'd0;
    else if (pick == 1) cnt = 7'd64;
    else if (pick == 2) cnt = 7'($urandom_range(65, 127));
    else                cnt = 7'($urandom_range(1, 8));
    push_item(op, 8'($urandom), cnt);
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset setup (256/256, notify off) ---
    push_item(OP_TX_READY, 8'h00, 7'd1);           // transmit ring empty
    push_item(OP_SW_READ, 8'h00, 7'd5);            // receive ring empty
    push_item(OP_SW_READ, 8'hFF, 7'd0);            // zero-length read
    push_item(OP_LINE_BYTE, 8'h00, 7'd0);
    push_item(OP_LINE_BYTE, 8'hFF, 7'h7F);
    push_item(OP_RX_ERROR, 8'hFF, 7'h7F);
    push_item(OP_TX_READY + 3'd1, 8'hFF, 7'h7F);   // unused codes change nothing
    push_item(OP_TX_READY + 3'd2, 8'h00, 7'd0);
    push_item(OP_TX_READY + 3'd3, 8'h5A, 7'd64);
    push_item(OP_SW_WRITE, 8'hA5, 7'd0);
    push_item(OP_SW_WRITE, 8'h00, 7'd0);
    push_item(OP_SW_WRITE, 8'hFF, 7'h7F);
    repeat (3) push_item(OP_TX_READY, 8'h00, 7'd0);
    push_item(OP_TX_READY, 8'h00, 7'd0);           // empty again
    push_item(OP_SW_READ, 8'h00, 7'h7F);           // above the cap, gets both bytes

    // --- directed, tiny rings: fill, drop, refuse, notify ---
    program_rings(9'd4, 9'd4, 16'hFFFF);
    repeat (4) push_item(OP_LINE_BYTE, 8'($urandom), 7'd1);  // last one dropped
    repeat (4) push_item(OP_SW_WRITE, 8'($urandom), 7'd1);   // last one refused
    push_item(OP_SW_READ, 8'h00, 7'd64);

    // --- random phases; first two pin the size extremes ---
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       program_rings(9'd0, 9'd1, 16'h0001);      // always full and empty
        1:       program_rings(9'd511, 9'd300, 16'h8000);  // saturate to full depth
        default: program_rings(pick_size(), pick_size(), pick_id());
      endcase
      // some phases run without idling; the last one always does
      calm = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) random_item();
    end

    settle(200);
    $display("Covered %0d input beats over %0d ring setups, %0d result beats checked.",
             sent, setups, checked);
    $display("Setups included zero, one, tiny and oversized rings with notify on and off.");
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", owed_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/uartrb_pkg.sv
hw/rtl/uartrb_ram.sv
hw/rtl/uartrb_core.sv
hw/rtl/uart_rx_tx_ring_buffers_top.sv
verif/uart_rings_checker.sv
verif/tb_uart_rx_tx_ring_buffers_top.sv
